>>> rtl/npc_pkg.sv
// Shared types and helpers for the nearest palette color search chain.
`timescale 1ns / 1ps

package npc_pkg;

    localparam int COLOR_W     = 8;
    localparam int DIST_W      = 10;
    localparam int SIZE_W      = 9;
    localparam int OUT_IDX_W   = 8;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [DIST_W-1:0] DIST_MAX   = '1;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [7:0]            entry_index;
        logic [COLOR_W-1:0]    red;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    blue;
        logic [DIST_W-1:0]     best_dist;
        logic [OUT_IDX_W-1:0]  best_index;
    } token_t;

    function automatic logic [COLOR_W-1:0] abs_diff8(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        abs_diff8 = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> rtl/npc_cell.sv
// One palette cell: holds one entry, captures loads, scores passing lookups.
`timescale 1ns / 1ps

module npc_cell #(
    parameter int CMP_W = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [CMP_W-1:0]  cell_id,
    input  logic              in_use,
    input  npc_pkg::token_t   tok_in,
    output npc_pkg::token_t   tok_out
);

    npc_pkg::token_t                     token_reg;
    npc_pkg::token_t                     token_next;
    logic [3*npc_pkg::COLOR_W-1:0]       entry_reg;
    logic [npc_pkg::DIST_W-1:0]          cand_dist;
    logic                                load_hit;
    logic                                is_lookup;

    assign load_hit  = tok_in.valid && (tok_in.kind == npc_pkg::KIND_LOAD)
                       && (CMP_W'(tok_in.entry_index) == cell_id);
    assign is_lookup = tok_in.valid && (tok_in.kind == npc_pkg::KIND_LOOKUP);

    always_comb begin
        cand_dist = npc_pkg::DIST_W'(npc_pkg::abs_diff8(entry_reg[23:16], tok_in.red))
                  + npc_pkg::DIST_W'(npc_pkg::abs_diff8(entry_reg[15:8], tok_in.green))
                  + npc_pkg::DIST_W'(npc_pkg::abs_diff8(entry_reg[7:0], tok_in.blue));
        token_next = tok_in;
        if (is_lookup && in_use && (cand_dist < tok_in.best_dist)) begin
            token_next.best_dist  = cand_dist;
            token_next.best_index = cell_id[npc_pkg::OUT_IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg.valid <= 1'b0;
        end else if (advance) begin
            token_reg <= token_next;
            if (load_hit) begin
                entry_reg <= {tok_in.red, tok_in.green, tok_in.blue};
            end
        end
    end

    assign tok_out = token_reg;

    a_dist_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tok_in.valid) |=> (token_reg.best_dist <= $past(tok_in.best_dist)))
        else $error("best distance grew across a cell");

    a_load_passes_unchanged: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tok_in.valid && (tok_in.kind == npc_pkg::KIND_LOAD))
        |=> (token_reg.best_dist == $past(tok_in.best_dist)
             && token_reg.best_index == $past(tok_in.best_index)))
        else $error("load transaction altered the running best");

endmodule

>>> rtl/nearest_palette_color_l1.sv
// Nearest palette color (L1) search: systolic chain of palette cells with output register.
// A lookup passes through every cell register, then the output register.
// Throughput: one transaction per unstalled cycle; loads and lookups share the chain.
// The whole chain stalls only while an unaccepted result sits in the output register.
// Reset (aresetn low, synchronous) clears the chain valid bits, the output valid and
// sets palette_size to 256; palette entries are undefined until loaded.
`timescale 1ns / 1ps

module nearest_palette_color_l1 #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_entry_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_color_index
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CMP_W = (IDX_W + 1 > npc_pkg::SIZE_W) ? IDX_W + 1 : npc_pkg::SIZE_W;

    logic [npc_pkg::SIZE_W-1:0]    palette_size_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [npc_pkg::OUT_IDX_W-1:0] out_index_reg;
    logic                          advance;
    logic                          last_is_lookup;
    npc_pkg::token_t               head_tok;
    npc_pkg::token_t               chain [0:PALETTE_DEPTH];

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    always_comb begin
        head_tok.valid       = s_valid;
        head_tok.kind        = npc_pkg::kind_t'(s_kind);
        head_tok.entry_index = s_entry_index;
        head_tok.red         = s_red;
        head_tok.green       = s_green;
        head_tok.blue        = s_blue;
        head_tok.best_dist   = npc_pkg::DIST_MAX;
        head_tok.best_index  = '0;
    end

    assign chain[0] = head_tok;

    for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
        logic [CMP_W-1:0] cell_id;
        logic             in_use;

        assign cell_id = CMP_W'(i);
        assign in_use  = cell_id < CMP_W'(palette_size_reg);

        npc_cell #(
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .cell_id (cell_id),
            .in_use  (in_use),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last_is_lookup = chain[PALETTE_DEPTH].valid
                            && (chain[PALETTE_DEPTH].kind == npc_pkg::KIND_LOOKUP);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = last_is_lookup;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_size_reg <= npc_pkg::SIZE_RESET;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                palette_size_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_is_lookup) begin
            out_index_reg <= chain[PALETTE_DEPTH].best_index;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_color_index = out_index_reg;

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid set after reset");

    a_lookup_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_is_lookup)
        |=> (m_valid && m_color_index == $past(chain[PALETTE_DEPTH].best_index)))
        else $error("lookup result lost at chain end");

    a_load_gives_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && chain[PALETTE_DEPTH].valid
         && (chain[PALETTE_DEPTH].kind == npc_pkg::KIND_LOAD)) |=> !m_valid)
        else $error("load transaction produced a result");

endmodule
